FILE: design/transparent_run_length_encoder_macros.svh
// Assertion macros shared by the encoder modules.
// All checks are clocked on clock and disabled while reset is high.
`ifndef TRANSPARENT_RUN_LENGTH_ENCODER_MACROS_SVH
`define TRANSPARENT_RUN_LENGTH_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TRLE_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("trle: invariant violated");

`define TRLE_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("trle: implication violated");

`define TRLE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("trle: next-cycle check violated");

`else

`define TRLE_ASSERT_ALWAYS(label, cond)

`define TRLE_ASSERT_IMPLY(label, ante, cons)

`define TRLE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: design/trle_pkg.sv
package trle_pkg;

   localparam logic [12:0] MAX_WIDTH    = 13'd4096;
   localparam logic [12:0] MAX_ROWS     = 13'd4096;
   localparam logic [6:0]  MAX_RUN      = 7'd127;
   localparam logic [7:0]  ROW_END_MARK = 8'h80;
   localparam int          LIT_DEPTH    = 128;

   // configuration register indexes
   localparam logic CSR_ROW_WIDTH = 1'b0;
   localparam logic CSR_ROW_COUNT = 1'b1;

   // byte sources for the emit path
   localparam logic [1:0] SRC_HDR  = 2'd0;
   localparam logic [1:0] SRC_LIT  = 2'd1;
   localparam logic [1:0] SRC_MARK = 2'd2;

   typedef struct packed {
      logic       load;     // capture the request pixel
      logic       append;   // add the pixel to the open run
      logic       close;    // empty the open run
      logic       advance;  // step column and row positions
      logic       emit;     // send one byte into the packing word
      logic [1:0] src;
      logic [1:0] lane;
      logic       push;     // move the packing word to the output register
      logic       final_item;
      logic [2:0] count;
   } cmd_type;

   typedef struct packed {
      logic active;       // column is inside the row's pixels
      logic close_first;  // the pixel ends the open run
      logic row_end;      // the pixel is the last of its row
      logic run_trans;    // the open run is transparent
      logic lit_last;     // literal read index is at the last stored byte
      logic out_free;     // the output register can take a word
   } status_type;

endpackage

FILE: design/trle_ctrl.sv
`include "transparent_run_length_encoder_macros.svh"

module trle_ctrl
   import trle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_EVAL   = 4'd1;
   localparam logic [3:0] S_HDR1   = 4'd2;
   localparam logic [3:0] S_LIT1   = 4'd3;
   localparam logic [3:0] S_APPEND = 4'd4;
   localparam logic [3:0] S_ROWEND = 4'd5;
   localparam logic [3:0] S_HDR2   = 4'd6;
   localparam logic [3:0] S_LIT2   = 4'd7;
   localparam logic [3:0] S_MARK   = 4'd8;
   localparam logic [3:0] S_PUSH   = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [3:0] resume_ff, resume_in;
   logic [2:0] fill_ff, fill_in;
   logic       final_ff, final_in;

   logic [3:0] after_emit;
   logic       last_byte;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      resume_in  = resume_ff;
      fill_in    = fill_ff;
      final_in   = final_ff;
      after_emit = state_ff;
      last_byte  = 1'b0;
      cmd.lane   = fill_ff[1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!status.active) begin
               cmd.advance = 1'b1;
               state_in    = S_IDLE;
            end else if (status.close_first) begin
               state_in = S_HDR1;
            end else begin
               cmd.append = 1'b1;
               if (status.row_end) begin
                  state_in = S_ROWEND;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         S_HDR1: begin
            cmd.emit   = 1'b1;
            cmd.src    = SRC_HDR;
            cmd.close  = status.run_trans;
            last_byte  = status.run_trans && !status.row_end;
            after_emit = status.run_trans ? S_APPEND : S_LIT1;
         end
         S_LIT1: begin
            cmd.emit   = 1'b1;
            cmd.src    = SRC_LIT;
            cmd.close  = status.lit_last;
            last_byte  = status.lit_last && !status.row_end;
            after_emit = status.lit_last ? S_APPEND : S_LIT1;
         end
         S_APPEND: begin
            cmd.append = 1'b1;
            if (status.row_end) begin
               state_in = S_ROWEND;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_ROWEND: begin
            state_in = status.run_trans ? S_MARK : S_HDR2;
         end
         S_HDR2: begin
            cmd.emit   = 1'b1;
            cmd.src    = SRC_HDR;
            after_emit = S_LIT2;
         end
         S_LIT2: begin
            cmd.emit   = 1'b1;
            cmd.src    = SRC_LIT;
            after_emit = status.lit_last ? S_MARK : S_LIT2;
         end
         S_MARK: begin
            cmd.emit   = 1'b1;
            cmd.src    = SRC_MARK;
            cmd.close  = 1'b1;
            last_byte  = 1'b1;
            after_emit = S_DONE;
         end
         S_PUSH: begin
            if (status.out_free) begin
               cmd.push       = 1'b1;
               cmd.count      = fill_ff;
               cmd.final_item = final_ff;
               fill_in        = '0;
               state_in       = resume_ff;
            end
         end
         S_DONE: begin
            cmd.advance = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a full word or the step's last byte goes out before anything else
      if (cmd.emit) begin
         fill_in = fill_ff + 3'd1;
         if (fill_ff == 3'd3 || last_byte) begin
            state_in  = S_PUSH;
            resume_in = after_emit;
            final_in  = last_byte;
         end else begin
            state_in = after_emit;
         end
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         resume_ff <= S_IDLE;
         fill_ff   <= '0;
         final_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         resume_ff <= resume_in;
         fill_ff   <= fill_in;
         final_ff  <= final_in;
      end
   end

   `TRLE_ASSERT_IMPLY(a_emit_has_room, cmd.emit, fill_ff < 3'd4)
   `TRLE_ASSERT_IMPLY(a_idle_word_empty, state_ff == S_IDLE, fill_ff == 3'd0)
   `TRLE_ASSERT_IMPLY(a_push_not_empty, state_ff == S_PUSH, fill_ff != 3'd0)

endmodule

FILE: design/trle_dpath.sv
`include "transparent_run_length_encoder_macros.svh"

module trle_dpath
   import trle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [12:0] csr_data,
   input  logic [7:0]  req_pixel,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_byte_a,
   output logic [7:0]  rsp_byte_b,
   output logic [7:0]  rsp_byte_c,
   output logic [7:0]  rsp_byte_d,
   output logic [2:0]  rsp_byte_count,
   output logic        rsp_last_of_step,
   output logic        rsp_image_done
);

   logic [12:0] row_width_ff, row_width_in;
   logic [12:0] row_count_ff, row_count_in;
   logic [12:0] column_ff, column_in;
   logic [11:0] row_ff, row_in;
   logic        run_trans_ff, run_trans_in;
   logic [6:0]  run_len_ff, run_len_in;
   logic [7:0]  pixel_ff, pixel_in;
   logic [6:0]  lit_idx_ff, lit_idx_in;
   logic        land_v_ff;
   logic [1:0]  land_src_ff;
   logic [1:0]  land_lane_ff;
   logic [7:0]  hdr_ff, hdr_in;
   logic [7:0]  rd_data_ff;
   logic [7:0]  word_ff [4];
   logic [7:0]  word_in [4];
   logic [7:0]  word_next [4];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_byte_ff [4];
   logic [2:0]  out_count_ff;
   logic        out_last_ff;
   logic        out_done_ff;

   logic [7:0]  lit_store_ff [LIT_DEPTH];

   logic [12:0] width_eff;
   logic [12:0] count_eff;
   logic [12:0] padded;
   logic [12:0] count_m1;
   logic        last_row;
   logic        pixel_trans;
   logic [12:0] column_inc;
   logic [7:0]  land_byte;

   // clamp the configured geometry
   always_comb begin
      if (row_width_ff == 13'd0) begin
         width_eff = 13'd1;
      end else if (row_width_ff > MAX_WIDTH) begin
         width_eff = MAX_WIDTH;
      end else begin
         width_eff = row_width_ff;
      end
      if (row_count_ff == 13'd0) begin
         count_eff = 13'd1;
      end else if (row_count_ff > MAX_ROWS) begin
         count_eff = MAX_ROWS;
      end else begin
         count_eff = row_count_ff;
      end
   end

   assign padded      = (width_eff + 13'd3) & ~13'd3;
   assign count_m1    = count_eff - 13'd1;
   assign last_row    = (row_ff >= count_m1[11:0]);
   assign pixel_trans = (pixel_ff == 8'd0);
   assign column_inc  = column_ff + 13'd1;

   assign status.active      = (column_ff < width_eff);
   assign status.row_end     = (column_ff == width_eff - 13'd1);
   assign status.close_first = status.active && (run_len_ff != 7'd0) &&
                               ((pixel_trans != run_trans_ff) || (run_len_ff >= MAX_RUN));
   assign status.run_trans   = run_trans_ff;
   assign status.lit_last    = (lit_idx_ff == run_len_ff - 7'd1);
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      row_width_in = row_width_ff;
      row_count_in = row_count_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ROW_WIDTH: row_width_in = csr_data;
            CSR_ROW_COUNT: row_count_in = csr_data;
         endcase
      end
   end

   // run and position state
   always_comb begin
      pixel_in     = cmd.load ? req_pixel : pixel_ff;
      run_len_in   = run_len_ff;
      run_trans_in = run_trans_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      if (cmd.append) begin
         if (run_len_ff == 7'd0) begin
            run_trans_in = pixel_trans;
         end
         run_len_in = run_len_ff + 7'd1;
      end
      if (cmd.close) begin
         run_len_in = 7'd0;
      end
      if (cmd.advance) begin
         column_in = column_inc;
         if (column_inc >= padded) begin
            column_in  = 13'd0;
            run_len_in = 7'd0;
            row_in     = last_row ? 12'd0 : row_ff + 12'd1;
         end
      end
   end

   // emit side: header byte and literal read are registered and land in the cycle after the emit
   always_comb begin
      hdr_in     = run_trans_ff ? (ROW_END_MARK | {1'b0, run_len_ff}) : {1'b0, run_len_ff};
      lit_idx_in = lit_idx_ff;
      if (cmd.emit && cmd.src == SRC_HDR) begin
         lit_idx_in = 7'd0;
      end else if (cmd.emit && cmd.src == SRC_LIT) begin
         lit_idx_in = lit_idx_ff + 7'd1;
      end
   end

   always_comb begin
      case (land_src_ff)
         SRC_HDR:  land_byte = hdr_ff;
         SRC_LIT:  land_byte = rd_data_ff;
         SRC_MARK: land_byte = ROW_END_MARK;
         default:  land_byte = 8'd0;
      endcase
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         word_next[i] = word_ff[i];
      end
      if (land_v_ff) begin
         word_next[land_lane_ff] = land_byte;
      end
      for (int i = 0; i < 4; i++) begin
         word_in[i] = cmd.push ? 8'd0 : word_next[i];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= 13'd1;
         row_count_ff <= 13'd1;
         column_ff    <= '0;
         row_ff       <= '0;
         run_trans_ff <= 1'b0;
         run_len_ff   <= '0;
         land_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            word_ff[i] <= '0;
         end
      end else begin
         row_width_ff <= row_width_in;
         row_count_ff <= row_count_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         run_trans_ff <= run_trans_in;
         run_len_ff   <= run_len_in;
         land_v_ff    <= cmd.emit;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 4; i++) begin
            word_ff[i] <= word_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff     <= pixel_in;
      lit_idx_ff   <= lit_idx_in;
      hdr_ff       <= hdr_in;
      land_src_ff  <= cmd.src;
      land_lane_ff <= cmd.lane;
      if (cmd.push) begin
         for (int i = 0; i < 4; i++) begin
            out_byte_ff[i] <= word_next[i];
         end
         out_count_ff <= cmd.count;
         out_last_ff  <= cmd.final_item;
         out_done_ff  <= cmd.final_item && status.row_end && last_row;
      end
   end

   // literal store: written on append, read one byte per literal emit
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         lit_store_ff[run_len_ff] <= pixel_ff;
      end
      rd_data_ff <= lit_store_ff[lit_idx_ff];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_a       = out_byte_ff[0];
   assign rsp_byte_b       = out_byte_ff[1];
   assign rsp_byte_c       = out_byte_ff[2];
   assign rsp_byte_d       = out_byte_ff[3];
   assign rsp_byte_count   = out_count_ff;
   assign rsp_last_of_step = out_last_ff;
   assign rsp_image_done   = out_done_ff;

   `TRLE_ASSERT_IMPLY(a_append_has_room, cmd.append, run_len_ff < MAX_RUN)
   `TRLE_ASSERT_IMPLY(a_lit_in_run, cmd.emit && cmd.src == SRC_LIT, lit_idx_ff < run_len_ff)
   `TRLE_ASSERT_IMPLY(a_push_when_free, cmd.push, !rsp_valid_ff || !rsp_stall)

endmodule

FILE: design/transparent_run_length_encoder.sv
// Transparent run-length encoder for 8-bit indexed sprite rows.
// Request channel: one padded row byte per request on req_pixel, taken when
// req_valid is high and req_stall is low. Padding bytes past row_width are
// dropped. Result channel: up to four coded bytes per item on rsp_byte_a..d,
// rsp_byte_count valid bytes (unused lanes read zero), rsp_last_of_step on the
// final item of a request and rsp_image_done on the item carrying the last
// row terminator of the image.
// Configuration: csr_write with csr_index 0 sets row_width, 1 sets row_count;
// write only while no request is in flight.
// On a run close or row end the literal store is read one byte per cycle through
// a single read port, pausing while each finished item is loaded into the output
// register, which waits while rsp_stall holds that register.
// Reset: synchronous; positions and run state clear, row_width and row_count
// return to 1, the output register empties. The literal store is not cleared.
// When rsp_stall holds the output register, the encoder keeps filling its
// packing word and then waits; a finished item does not block the next
// request from being taken.

module transparent_run_length_encoder
   import trle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [12:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_byte_a,
   output logic [7:0]  rsp_byte_b,
   output logic [7:0]  rsp_byte_c,
   output logic [7:0]  rsp_byte_d,
   output logic [2:0]  rsp_byte_count,
   output logic        rsp_last_of_step,
   output logic        rsp_image_done
);

   cmd_type    cmd;
   status_type status;

   // sequence each request: classify, drain a closed run, append, end row
   trle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // hold positions, run state, literal store, packing word, output register
   trle_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_pixel        (req_pixel),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_a       (rsp_byte_a),
      .rsp_byte_b       (rsp_byte_b),
      .rsp_byte_c       (rsp_byte_c),
      .rsp_byte_d       (rsp_byte_d),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_image_done   (rsp_image_done)
   );

endmodule
